>>> rtl/ple_pkg.sv
package ple_pkg;

   localparam int CELL_GROUP = 32;

   localparam logic [2:0] OP_INS_FRONT = 3'd0;
   localparam logic [2:0] OP_INS_BACK  = 3'd1;
   localparam logic [2:0] OP_INS_AT    = 3'd2;
   localparam logic [2:0] OP_REM_FRONT = 3'd3;
   localparam logic [2:0] OP_REM_BACK  = 3'd4;
   localparam logic [2:0] OP_REM_AT    = 3'd5;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [6:0]  position;
      logic [15:0] entry_value;
   } ple_req_type;

   typedef struct packed {
      logic [15:0] removed_value;
      logic [1:0]  status;
      logic [6:0]  entry_count;
   } ple_rsp_type;

   typedef struct packed {
      logic ins;
      logic rem;
      logic capture;
   } ple_ctl_type;

endpackage

>>> rtl/ple_cell.sv
module ple_cell #(
   parameter int VALUE_BITS = 16,
   parameter int CMP_W      = 7,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  ple_pkg::ple_ctl_type    ctl,
   input  logic [CMP_W-1:0]        tgt,
   input  logic [VALUE_BITS-1:0]   new_value,
   input  logic [VALUE_BITS-1:0]   left_value,
   input  logic [VALUE_BITS-1:0]   right_value,
   output logic [VALUE_BITS-1:0]   value,
   output logic [VALUE_BITS-1:0]   sel_value
);
   import ple_pkg::*;

   localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         if (MY_IDX > tgt) begin
            value_in = left_value;
         end else if (MY_IDX == tgt) begin
            value_in = new_value;
         end
      end else if (ctl.rem) begin
         if (MY_IDX >= tgt) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign sel_value = (ctl.rem && (tgt == MY_IDX)) ? value_ff : '0;

endmodule

>>> rtl/ple_row.sv
module ple_row #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16,
   parameter int CMP_W      = 7,
   parameter int NUM_GROUPS = 2
) (
   input  logic                                  clock,
   input  ple_pkg::ple_ctl_type                  ctl,
   input  logic [CMP_W-1:0]                      tgt,
   input  logic [VALUE_BITS-1:0]                 new_value,
   output logic [NUM_GROUPS-1:0][VALUE_BITS-1:0] grp_values
);
   import ple_pkg::*;

   localparam int PAD = NUM_GROUPS * CELL_GROUP;

   logic [CAPACITY-1:0][VALUE_BITS-1:0] cell_value;
   logic [PAD-1:0][VALUE_BITS-1:0]      sel_pad;
   logic [NUM_GROUPS-1:0][VALUE_BITS-1:0] grp_ff;
   logic [NUM_GROUPS-1:0][VALUE_BITS-1:0] grp_in;

   for (genvar k = 0; k < PAD; k++) begin : g_cell
      if (k < CAPACITY) begin : g_real
         logic [VALUE_BITS-1:0] left_value;
         logic [VALUE_BITS-1:0] right_value;
         if (k == 0) begin : g_first
            assign left_value = cell_value[k];
         end else begin : g_mid_l
            assign left_value = cell_value[k-1];
         end
         if (k == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[k];
         end else begin : g_mid_r
            assign right_value = cell_value[k+1];
         end
         ple_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CMP_W      (CMP_W),
            .INDEX      (k)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .tgt         (tgt),
            .new_value   (new_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[k]),
            .sel_value   (sel_pad[k])
         );
      end else begin : g_pad
         assign sel_pad[k] = '0;
      end
   end

   // first level of the removed value reduction
   always_comb begin
      grp_in = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         for (int i = 0; i < CELL_GROUP; i++) begin
            grp_in[g] = grp_in[g] | sel_pad[g*CELL_GROUP + i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         grp_ff <= grp_in;
      end
   end

   assign grp_values = grp_ff;

endmodule

>>> rtl/positional_list_engine_core.sv
// channel  | ports                              | carries
// request  | req_valid, req_stall, req_payload  | opcode, position, entry_value
// result   | rsp_valid, rsp_stall, rsp_payload  | removed_value, status, entry_count
//
// each request runs capture, cell row update, removed value reduction in turn
// every cell shifts in the same cycle, so the number of steps does not depend on CAPACITY
// the result register lets the next request in while a result waits
// reset empties the list; cell contents are not cleared
module positional_list_engine_core #(
   parameter int CAPACITY   = 64,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ple_pkg::ple_req_type  req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ple_pkg::ple_rsp_type  rsp_payload
);
   import ple_pkg::*;

   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CMP_W      = (CNT_W > 7) ? CNT_W : 7;
   localparam int NUM_GROUPS = (CAPACITY + CELL_GROUP - 1) / CELL_GROUP;
   localparam int WIDE       = (VALUE_BITS > 16) ? VALUE_BITS : 16;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   ple_req_type cmd_ff, cmd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]  status_ff, status_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ple_rsp_type rsp_ff, rsp_in;

   ple_ctl_type ctl;
   logic [CMP_W-1:0] tgt;
   logic [CMP_W-1:0] cnt_ext;
   logic [CMP_W-1:0] pos_ext;
   logic [WIDE-1:0]  new_wide;
   logic [WIDE-1:0]  rem_wide;
   logic [VALUE_BITS-1:0] new_value;
   logic [VALUE_BITS-1:0] removed;
   logic [NUM_GROUPS-1:0][VALUE_BITS-1:0] grp_values;
   logic        load;

   assign cnt_ext   = CMP_W'(cnt_ff);
   assign pos_ext   = CMP_W'(cmd_ff.position);
   assign new_wide  = WIDE'(cmd_ff.entry_value);
   assign new_value = new_wide[VALUE_BITS-1:0];

   always_comb begin
      unique case (cmd_ff.opcode)
         OP_INS_BACK:  tgt = cnt_ext;
         OP_INS_AT:    tgt = pos_ext;
         OP_REM_BACK:  tgt = cnt_ext - CMP_W'(1);
         OP_REM_AT:    tgt = pos_ext;
         default:      tgt = '0;
      endcase
   end

   always_comb begin
      status_in = status_ff;
      cnt_in    = cnt_ff;
      ctl       = '0;
      if (state_ff == S_EXEC) begin
         ctl.capture = 1'b1;
         status_in   = ST_OK;
         unique case (cmd_ff.opcode) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
               if (tgt > cnt_ext) begin
                  status_in = ST_BADPOS;
               end else if (cnt_ff == CNT_W'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  ctl.ins = 1'b1;
                  cnt_in  = cnt_ff + CNT_W'(1);
               end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
               if (cnt_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (tgt >= cnt_ext) begin
                  status_in = ST_BADPOS;
               end else begin
                  ctl.rem = 1'b1;
                  cnt_in  = cnt_ff - CNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   ple_row #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS),
      .CMP_W      (CMP_W),
      .NUM_GROUPS (NUM_GROUPS)
   ) u_row (
      .clock      (clock),
      .ctl        (ctl),
      .tgt        (tgt),
      .new_value  (new_value),
      .grp_values (grp_values)
   );

   always_comb begin
      removed = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         removed = removed | grp_values[g];
      end
   end

   assign rem_wide = WIDE'(removed);
   assign load     = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload;
               state_in = S_EXEC;
            end
         end
         S_EXEC: state_in = S_DONE;
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_in.removed_value = rem_wide[15:0];
         rsp_in.status        = status_ff;
         rsp_in.entry_count   = cnt_ext[6:0];
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
